>>> src/quadrature_sine_oscillator_defines.svh
// Assertion helpers used by the oscillator RTL.
`ifndef QUADRATURE_SINE_OSCILLATOR_DEFINES_SVH
`define QUADRATURE_SINE_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define QSO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qso: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define QSO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qso: next-cycle check failed");

`endif

>>> src/qso_pkg.sv
package qso_pkg;

  localparam int COEFF_FRAC_BITS = 30;
  localparam int SAMPLE_BITS     = 16;
  localparam int OUT_BITS        = SAMPLE_BITS + 2;
  localparam int PH_W            = 32;
  localparam int PROD_W          = 2 * PH_W;
  localparam int ACC_W           = PROD_W + 1;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W       = 3;

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(2 ** (COEFF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] ACC_PMAX =
    {{(ACC_W - PH_W + 1){1'b0}}, {(PH_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_PMIN =
    {{(ACC_W - PH_W + 1){1'b1}}, {(PH_W - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_OMAX =
    {{(ACC_W - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_OMIN =
    {{(ACC_W - OUT_BITS + 1){1'b1}}, {(OUT_BITS - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_COS   = 3'd0,
    REG_ROT_SIN   = 3'd1,
    REG_START_X   = 3'd2,
    REG_START_Y   = 3'd3,
    REG_DC_OFFSET = 3'd4,
    REG_AMPLITUDE = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CX,
    ST_SY,
    ST_CY,
    ST_SX,
    ST_AM,
    ST_OUT
  } state_t;

  // Scale down by the fraction bits (rounding already folded into v),
  // then saturate to the phasor range.
  function automatic logic signed [PH_W-1:0] shift_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] sh;
    sh = v >>> COEFF_FRAC_BITS;
    if (sh > ACC_PMAX) begin
      shift_sat = ACC_PMAX[PH_W-1:0];
    end else if (sh < ACC_PMIN) begin
      shift_sat = ACC_PMIN[PH_W-1:0];
    end else begin
      shift_sat = sh[PH_W-1:0];
    end
  endfunction

endpackage

>>> src/quadrature_sine_oscillator.sv
// Quadrature sine oscillator. A phasor (x, y) in Q2.30 is rotated once per
// input transaction by the programmed cos/sin step, and each transaction
// yields one sample: dc_offset + x' * amplitude (rounded, saturated to 18 bits).
// Setting restart (in_tdata[0]) reloads the phasor from start_x/start_y before
// the rotation; after reset the phasor is zero, so the first transaction should
// restart. All five products go through one 32x32 multiplier in turn, so each
// transaction passes the accept state, the multiplier states CX, SY, CY, SX and
// AM, and the output state; in_tready comes back only on the return to idle.
// A sample still held in the output register stretches the output state until
// it is taken. A new transaction may be accepted while a sample waits. The
// configuration port is always ready; write it only while the block is idle.
module quadrature_sine_oscillator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: [0] restart, rest zero
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [qso_pkg::IN_TDATA_W-1:0]         in_tdata,
  // out_tdata: [17:0] sample (signed), rest zero
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [qso_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [qso_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [qso_pkg::PH_W-1:0]               cfg_data
);

  `include "quadrature_sine_oscillator_defines.svh"

  // Configuration registers
  logic signed [qso_pkg::PH_W-1:0]        rot_cos_r, rot_sin_r, start_x_r, start_y_r;
  logic signed [qso_pkg::SAMPLE_BITS-1:0] dc_offset_r;
  logic [qso_pkg::SAMPLE_BITS-1:0]        amplitude_r;

  // Sequencer and datapath
  qso_pkg::state_t                        state_r, state_nxt;
  logic signed [qso_pkg::PH_W-1:0]        x_r, y_r, nx_r;
  logic signed [qso_pkg::ACC_W-1:0]       acc_r;
  logic signed [qso_pkg::PH_W-1:0]        mul_a, mul_b;
  logic signed [qso_pkg::PROD_W-1:0]      prod_r;
  logic signed [qso_pkg::ACC_W-1:0]       prod_ext;
  logic signed [qso_pkg::ACC_W-1:0]       samp_sum;
  logic signed [qso_pkg::OUT_BITS-1:0]    samp_sat;
  logic                                   out_tvalid_r;
  logic signed [qso_pkg::OUT_BITS-1:0]    out_sample_r;
  logic                                   in_acc;
  logic                                   out_load;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign prod_ext  = qso_pkg::ACC_W'(prod_r);

  // Output load: in the output state with the slot either empty or being drained this cycle.
  assign out_load  = (state_r == qso_pkg::ST_OUT) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_cos_r   <= qso_pkg::PH_W'(2 ** qso_pkg::COEFF_FRAC_BITS);
      rot_sin_r   <= '0;
      start_x_r   <= qso_pkg::PH_W'(2 ** qso_pkg::COEFF_FRAC_BITS);
      start_y_r   <= '0;
      dc_offset_r <= '0;
      amplitude_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qso_pkg::REG_ROT_COS:   rot_cos_r   <= cfg_data;
        qso_pkg::REG_ROT_SIN:   rot_sin_r   <= cfg_data;
        qso_pkg::REG_START_X:   start_x_r   <= cfg_data;
        qso_pkg::REG_START_Y:   start_y_r   <= cfg_data;
        qso_pkg::REG_DC_OFFSET: dc_offset_r <= cfg_data[qso_pkg::SAMPLE_BITS-1:0];
        qso_pkg::REG_AMPLITUDE: amplitude_r <= cfg_data[qso_pkg::SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qso_pkg::ST_IDLE: if (in_acc) state_nxt = qso_pkg::ST_CX;
      qso_pkg::ST_CX:   state_nxt = qso_pkg::ST_SY;
      qso_pkg::ST_SY:   state_nxt = qso_pkg::ST_CY;
      qso_pkg::ST_CY:   state_nxt = qso_pkg::ST_SX;
      qso_pkg::ST_SX:   state_nxt = qso_pkg::ST_AM;
      qso_pkg::ST_AM:   state_nxt = qso_pkg::ST_OUT;
      qso_pkg::ST_OUT:  if (out_load) state_nxt = qso_pkg::ST_IDLE;
      default:          state_nxt = qso_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and multiplier operand select.
  // Product of a state appears in prod_r during the following state.
  always_comb begin
    in_tready = 1'b0;
    mul_a     = rot_cos_r;
    mul_b     = x_r;
    unique case (state_r)
      qso_pkg::ST_IDLE: in_tready = 1'b1;
      qso_pkg::ST_CX: begin
        mul_a = rot_cos_r;
        mul_b = x_r;
      end
      qso_pkg::ST_SY: begin
        mul_a = rot_sin_r;
        mul_b = y_r;
      end
      qso_pkg::ST_CY: begin
        mul_a = rot_cos_r;
        mul_b = y_r;
      end
      qso_pkg::ST_SX: begin
        mul_a = rot_sin_r;
        mul_b = x_r;
      end
      // Operands held through the output step so x'*amp stays put while stalled
      qso_pkg::ST_AM, qso_pkg::ST_OUT: begin
        mul_a = nx_r;
        mul_b = qso_pkg::PH_W'(amplitude_r);  // zero-extended, stays positive
      end
      default: ;
    endcase
  end

  qso_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  // Sample: round x'*amp by the fraction bits, add offset, saturate.
  assign samp_sum = ((prod_ext + qso_pkg::ACC_HALF) >>> qso_pkg::COEFF_FRAC_BITS)
                    + qso_pkg::ACC_W'(dc_offset_r);

  always_comb begin
    if (samp_sum > qso_pkg::ACC_OMAX) begin
      samp_sat = qso_pkg::ACC_OMAX[qso_pkg::OUT_BITS-1:0];
    end else if (samp_sum < qso_pkg::ACC_OMIN) begin
      samp_sat = qso_pkg::ACC_OMIN[qso_pkg::OUT_BITS-1:0];
    end else begin
      samp_sat = samp_sum[qso_pkg::OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qso_pkg::ST_IDLE;
      x_r     <= '0;
      y_r     <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        qso_pkg::ST_IDLE: begin
          if (in_acc && in_tdata[0]) begin
            x_r <= start_x_r;
            y_r <= start_y_r;
          end
        end
        qso_pkg::ST_AM: begin
          // prod_r = sin*x; y' = cos*y - sin*x
          x_r <= nx_r;
          y_r <= qso_pkg::shift_sat(acc_r - prod_ext);
        end
        default: ;
      endcase
    end
  end

  // Accumulator and x' hold payload only
  always_ff @(posedge clk) begin
    unique case (state_r)
      qso_pkg::ST_SY: acc_r <= prod_ext + qso_pkg::ACC_HALF;           // cos*x
      qso_pkg::ST_CY: nx_r  <= qso_pkg::shift_sat(acc_r + prod_ext);  // + sin*y
      qso_pkg::ST_SX: acc_r <= prod_ext + qso_pkg::ACC_HALF;           // cos*y
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= samp_sat;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = qso_pkg::OUT_TDATA_W'($unsigned(out_sample_r));

  // Busy after every accepted transaction
  `QSO_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready)
  // Restart loads the start phase
  `QSO_ASSERT_NEXT(a_restart_load, in_acc && in_tdata[0], x_r == $past(start_x_r))
  // Sequencer waits while the previous sample is still held
  `QSO_ASSERT_NEXT(a_hold_on_stall,
    state_r == qso_pkg::ST_OUT && out_tvalid_r && !out_tready, state_r == qso_pkg::ST_OUT)
  // A new sample only comes from the output step
  `QSO_ASSERT_NOW(a_valid_source, $rose(out_tvalid_r), $past(state_r) == qso_pkg::ST_OUT)

endmodule

>>> src/qso_mul.sv
// Shared signed multiplier, product registered.
module qso_mul (
  input  logic                                clk,
  input  logic signed [qso_pkg::PH_W-1:0]     a,
  input  logic signed [qso_pkg::PH_W-1:0]     b,
  output logic signed [qso_pkg::PROD_W-1:0]   p_r
);

  logic signed [qso_pkg::PROD_W-1:0] p_nxt;

  assign p_nxt = a * b;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule
